[rtl/core/bpc_pkg.sv]
package bpc_pkg;

  localparam int unsigned DivBits = 32;
  localparam int unsigned SideW   = 64;

  localparam logic [31:0] TOffsetB6 = 32'd4000;
  localparam logic [31:0] TRound    = 32'd8;
  localparam logic [31:0] McScale   = 32'd2048;
  localparam logic [31:0] B4Bias    = 32'd32768;
  localparam logic [31:0] B3Round   = 32'd2;
  localparam logic [31:0] PScale    = 32'd50000;
  localparam logic [31:0] PCoefSq   = 32'd3038;
  localparam int          PCoefLin  = -7357;
  localparam logic [31:0] PCoefOfs  = 32'd3791;
  localparam int          PressMax  = 262143;

  typedef enum logic [2:0] {
    RegAc123 = 3'd0,
    RegAc456 = 3'd1,
    RegB1B2  = 3'd2,
    RegMcMd  = 3'd3,
    RegOss   = 3'd4
  } cfg_reg_e;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
    return 32'(a * b);
  endfunction

  function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input logic [4:0] k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = x + bias;
    return 32'($signed(sum) >>> k);
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] x);
    logic [15:0] r;
    if ($signed(x) > 32'sd32767) begin
      r = 16'h7FFF;
    end else if ($signed(x) < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/bpc_udiv.sv]
module bpc_udiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [31:0]                dividend_i,
  input  logic [31:0]                divisor_i,
  input  logic [bpc_pkg::SideW-1:0]  side_i,
  output logic                       valid_o,
  output logic [31:0]                quotient_o,
  output logic [bpc_pkg::SideW-1:0]  side_o
);

  localparam int unsigned N = bpc_pkg::DivBits;

  logic                       v_q   [N];
  logic [31:0]                rem_q [N];
  logic [31:0]                nq_q  [N];
  logic [31:0]                dvs_q [N];
  logic [bpc_pkg::SideW-1:0]  side_q[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      v_in;
    logic [31:0]               rem_in;
    logic [31:0]               nq_in;
    logic [31:0]               dvs_in;
    logic [bpc_pkg::SideW-1:0] side_in;
    logic [32:0]               trial;
    logic [32:0]               diff;
    logic                      ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = 32'd0;
      assign nq_in   = dividend_i;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, nq_in[31]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[31:0] : trial[31:0];
      nq_q[k]   <= {nq_in[30:0], ge};
      dvs_q[k]  <= dvs_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o    = v_q[N-1];
  assign quotient_o = nq_q[N-1];
  assign side_o     = side_q[N-1];

endmodule

[rtl/core/barometric_pressure_compensation.sv]
// Channel   | Direction | Handshake             | Payload
// config    | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
// request   | in        | start & !busy         | raw_temperature_i, raw_pressure_i
// result    | out       | valid_o (one cycle)   | temperature_o, pressure_o, status_o
//
// One request is taken every cycle; busy stays low.
// Two 32-stage restoring dividers (one quotient bit per stage) form the pipeline,
// with 19 arithmetic stages around them.
// Reset clears the valid bits and the configuration registers.
// Nothing stalls: every result is shown for one cycle and the receiver takes it.
module barometric_pressure_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        raw_temperature_i,
  input  logic [18:0]        raw_pressure_i,
  output logic               valid_o,
  output logic signed [15:0] temperature_o,
  output logic [17:0]        pressure_o,
  output logic               status_o
);

  localparam int unsigned Latency = 83;

  typedef struct packed {
    logic [18:0] up;
    logic        dz;
    logic [15:0] t;
  } carry_t;

  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b1b2_q, mcmd_q;
  logic [1:0]  oss_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign ac1 = bpc_pkg::sext16(ac123_q[47:32]);
  assign ac2 = bpc_pkg::sext16(ac123_q[31:16]);
  assign ac3 = bpc_pkg::sext16(ac123_q[15:0]);
  assign ac4 = {16'd0, ac456_q[47:32]};
  assign ac5 = {16'd0, ac456_q[31:16]};
  assign ac6 = {16'd0, ac456_q[15:0]};
  assign b1  = bpc_pkg::sext16(b1b2_q[31:16]);
  assign b2  = bpc_pkg::sext16(b1b2_q[15:0]);
  assign mc  = bpc_pkg::sext16(mcmd_q[31:16]);
  assign md  = bpc_pkg::sext16(mcmd_q[15:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac123_q <= '0;
      ac456_q <= '0;
      b1b2_q  <= '0;
      mcmd_q  <= '0;
      oss_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::RegAc123: ac123_q <= cfg_data_i;
        bpc_pkg::RegAc456: ac456_q <= cfg_data_i;
        bpc_pkg::RegB1B2:  b1b2_q  <= cfg_data_i[31:0];
        bpc_pkg::RegMcMd:  mcmd_q  <= cfg_data_i[31:0];
        bpc_pkg::RegOss:   oss_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [3:0] v1_q;
  logic [8:0] v2_q;
  logic [5:0] v3_q;
  logic       div1_v, div2_v;
  logic [31:0] div1_q, div2_q;
  logic [bpc_pkg::SideW-1:0] div1_side, div2_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0;
      v2_q <= '0;
      v3_q <= '0;
    end else begin
      v1_q <= {v1_q[2:0], accept};
      v2_q <= {v2_q[7:0], div1_v};
      v3_q <= {v3_q[4:0], div2_v};
    end
  end

  // temperature front end
  logic [15:0] ut_q;
  logic [18:0] up0_q, up1_q, up2_q;
  logic [31:0] tprod_q, x1t_q, dt_q;
  logic [31:0] dvd1_q, dvs1_q;
  logic [bpc_pkg::SideW-1:0] side1_q;

  logic [31:0] an, dabs, aabs;
  logic        neg, dz;

  assign dz   = (dt_q == 32'd0);
  assign an   = bpc_pkg::mulw(mc, bpc_pkg::McScale);
  assign neg  = an[31] ^ dt_q[31];
  assign aabs = an[31] ? (32'd0 - an) : an;
  assign dabs = dt_q[31] ? (32'd0 - dt_q) : dt_q;

  always_ff @(posedge clk_i) begin
    ut_q    <= raw_temperature_i;
    up0_q   <= raw_pressure_i;
    tprod_q <= bpc_pkg::mulw({16'd0, ut_q} - ac6, ac5);
    up1_q   <= up0_q;
    x1t_q   <= bpc_pkg::sdiv_p2(tprod_q, 5'd15);
    dt_q    <= bpc_pkg::sdiv_p2(tprod_q, 5'd15) + md;
    up2_q   <= up1_q;
    dvd1_q  <= aabs;
    dvs1_q  <= dabs;
    side1_q <= {11'd0, x1t_q, up2_q, dz, neg};
  end

  bpc_udiv u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q[3]),
    .dividend_i (dvd1_q),
    .divisor_i  (dvs1_q),
    .side_i     (side1_q),
    .valid_o    (div1_v),
    .quotient_o (div1_q),
    .side_o     (div1_side)
  );

  // pressure coefficients
  carry_t      cr_q [9];
  logic [31:0] b5_q, b6_q;
  logic [31:0] mbb_q, mac2_q, mac3_q;
  logic [31:0] sq_q, x2a_q, x1c_q, x2a4_q, x1c4_q;
  logic [31:0] mb2_q, mb1_q, x2a5_q, x1c5_q;
  logic [31:0] x1a_q, x2b_q;
  logic [31:0] b3_q, x3b_q;
  logic [31:0] b4p_q, b7_q;
  logic [31:0] dvd2_q, dvs2_q;
  logic [bpc_pkg::SideW-1:0] side2_q;

  logic [31:0] x2t, x3a, b3pre, b4;
  logic [18:0] s_up;
  logic [31:0] s_x1;

  assign s_x1  = div1_side[52:21];
  assign s_up  = div1_side[20:2];
  assign x2t   = div1_side[0] ? (32'd0 - div1_q) : div1_q;
  assign x3a   = x1a_q + x2a5_q;
  assign b3pre = ((bpc_pkg::mulw(ac1, 32'd4) + x3a) << oss_q) + bpc_pkg::B3Round;
  assign b4    = b4p_q >> 15;

  always_ff @(posedge clk_i) begin
    b5_q     <= s_x1 + x2t;
    cr_q[0]  <= '{up: s_up, dz: div1_side[1], t: 16'd0};
    b6_q     <= b5_q - bpc_pkg::TOffsetB6;
    cr_q[1]  <= '{up: cr_q[0].up, dz: cr_q[0].dz,
                  t: bpc_pkg::sat16(bpc_pkg::sdiv_p2(b5_q + bpc_pkg::TRound, 5'd4))};
    for (int k = 2; k < 9; k++) begin
      cr_q[k] <= cr_q[k-1];
    end
    mbb_q    <= bpc_pkg::mulw(b6_q, b6_q);
    mac2_q   <= bpc_pkg::mulw(ac2, b6_q);
    mac3_q   <= bpc_pkg::mulw(ac3, b6_q);
    sq_q     <= bpc_pkg::sdiv_p2(mbb_q, 5'd12);
    x2a_q    <= bpc_pkg::sdiv_p2(mac2_q, 5'd11);
    x1c_q    <= bpc_pkg::sdiv_p2(mac3_q, 5'd13);
    mb2_q    <= bpc_pkg::mulw(b2, sq_q);
    mb1_q    <= bpc_pkg::mulw(b1, sq_q);
    x2a4_q   <= x2a_q;
    x1c4_q   <= x1c_q;
    x1a_q    <= bpc_pkg::sdiv_p2(mb2_q, 5'd11);
    x2b_q    <= bpc_pkg::sdiv_p2(mb1_q, 5'd16);
    x2a5_q   <= x2a4_q;
    x1c5_q   <= x1c4_q;
    b3_q     <= bpc_pkg::sdiv_p2(b3pre, 5'd2);
    x3b_q    <= bpc_pkg::sdiv_p2(x1c5_q + x2b_q + bpc_pkg::B3Round, 5'd2);
    b4p_q    <= bpc_pkg::mulw(ac4, x3b_q + bpc_pkg::B4Bias);
    b7_q     <= bpc_pkg::mulw({13'd0, cr_q[6].up} - b3_q, bpc_pkg::PScale >> oss_q);
    dvd2_q   <= b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
    dvs2_q   <= b4;
    side2_q  <= {46'd0, cr_q[7].t, cr_q[7].dz || (b4 == 32'd0), b7_q[31]};
  end

  bpc_udiv u_div2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2_q[8]),
    .dividend_i (dvd2_q),
    .divisor_i  (dvs2_q),
    .side_i     (side2_q),
    .valid_o    (div2_v),
    .quotient_o (div2_q),
    .side_o     (div2_side)
  );

  // pressure back end
  logic [31:0] p_q   [5];
  logic [15:0] pt_q  [5];
  logic        pst_q [5];
  logic [31:0] qq_q, mlin1_q, mlin2_q, mlin3_q, qsq_q, msq_q, x1p_q, x2p_q;
  logic [31:0] pfin;

  assign pfin = p_q[4] + bpc_pkg::sdiv_p2(x1p_q + x2p_q + bpc_pkg::PCoefOfs, 5'd4);

  always_ff @(posedge clk_i) begin
    p_q[0]   <= div2_side[0] ? {div2_q[30:0], 1'b0} : div2_q;
    pt_q[0]  <= div2_side[17:2];
    pst_q[0] <= div2_side[1];
    for (int k = 1; k < 5; k++) begin
      p_q[k]   <= p_q[k-1];
      pt_q[k]  <= pt_q[k-1];
      pst_q[k] <= pst_q[k-1];
    end
    qq_q    <= bpc_pkg::sdiv_p2(p_q[0], 5'd8);
    mlin1_q <= bpc_pkg::mulw(32'(bpc_pkg::PCoefLin), p_q[0]);
    qsq_q   <= bpc_pkg::mulw(qq_q, qq_q);
    mlin2_q <= mlin1_q;
    msq_q   <= bpc_pkg::mulw(qsq_q, bpc_pkg::PCoefSq);
    mlin3_q <= mlin2_q;
    x1p_q   <= bpc_pkg::sdiv_p2(msq_q, 5'd16);
    x2p_q   <= bpc_pkg::sdiv_p2(mlin3_q, 5'd16);
    if (pst_q[4]) begin
      temperature_o <= '0;
      pressure_o    <= '0;
      status_o      <= 1'b1;
    end else begin
      temperature_o <= pt_q[4];
      status_o      <= 1'b0;
      if (pfin[31]) begin
        pressure_o <= '0;
      end else if ($signed(pfin) > 32'sd262143) begin
        pressure_o <= 18'(bpc_pkg::PressMax);
      end else begin
        pressure_o <= pfin[17:0];
      end
    end
  end

  assign valid_o = v3_q[5];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Latency))
    else $error("result without matching request");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div1_v |-> $past(v1_q[3], bpc_pkg::DivBits))
    else $error("divider valid misaligned");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (temperature_o == 16'sd0 && pressure_o == 18'd0))
    else $error("fault result not cleared");

endmodule

[bench/barometric_pressure_compensation_test.sv]
`timescale 1ns / 1ps
module barometric_pressure_compensation_test;

  localparam int unsigned Latency = 83;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [17:0]        pressure;
    logic               status;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] raw_temperature_i = '0;
  logic [18:0] raw_pressure_i = '0;
  logic        valid_o;
  logic signed [15:0] temperature_o;
  logic [17:0] pressure_o;
  logic        status_o;

  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b1b2_q, mcmd_q;
  logic [1:0]  oss_q;

  reading_t    compensated_q[$];
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;

  barometric_pressure_compensation dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("barometric_pressure_compensation_test failed");
      $finish;
    end
  end

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    longint sa, sb;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    return 32'(sa / sb);
  endfunction

  function automatic reading_t compensate(logic [15:0] ut, logic [18:0] up);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, d, b5, t, b6, sq, b3, b4, b7, p, q;
    longint tv, pv;
    reading_t r;
    ac1 = ext16(ac123_q[47:32]);
    ac2 = ext16(ac123_q[31:16]);
    ac3 = ext16(ac123_q[15:0]);
    ac4 = {16'd0, ac456_q[47:32]};
    ac5 = {16'd0, ac456_q[31:16]};
    ac6 = {16'd0, ac456_q[15:0]};
    b1 = ext16(b1b2_q[31:16]);
    b2 = ext16(b1b2_q[15:0]);
    mc = ext16(mcmd_q[31:16]);
    md = ext16(mcmd_q[15:0]);
    r = '{temperature: '0, pressure: '0, status: 1'b1};
    x1 = sdiv(32'(({16'd0, ut} - ac6) * ac5), 32'd32768);
    d = x1 + md;
    if (d == 0) return r;
    x2 = sdiv(32'(mc * 32'd2048), d);
    b5 = x1 + x2;
    t = sdiv(b5 + 32'd8, 32'd16);
    b6 = b5 - 32'd4000;
    sq = sdiv(32'(b6 * b6), 32'd4096);
    x1 = sdiv(32'(b2 * sq), 32'd2048);
    x2 = sdiv(32'(ac2 * b6), 32'd2048);
    x3 = x1 + x2;
    b3 = sdiv(((32'(ac1 * 32'd4) + x3) << oss_q) + 32'd2, 32'd4);
    x1 = sdiv(32'(ac3 * b6), 32'd8192);
    x2 = sdiv(32'(b1 * sq), 32'd65536);
    x3 = sdiv(x1 + x2 + 32'd2, 32'd4);
    b4 = 32'(ac4 * (x3 + 32'd32768)) / 32'd32768;
    if (b4 == 0) return r;
    b7 = 32'(({13'd0, up} - b3) * (32'd50000 >> oss_q));
    if (b7 < 32'h8000_0000) p = 32'(b7 * 32'd2) / b4;
    else p = 32'((b7 / b4) * 32'd2);
    q = sdiv(p, 32'd256);
    x1 = 32'(q * q);
    x1 = sdiv(32'(x1 * 32'd3038), 32'd65536);
    x2 = sdiv(32'(32'(-7357) * p), 32'd65536);
    p = p + sdiv(x1 + x2 + 32'd3791, 32'd16);
    tv = longint'($signed(t));
    if (tv > 32767) tv = 32767;
    if (tv < -32768) tv = -32768;
    pv = longint'($signed(p));
    if (pv > 262143) pv = 262143;
    if (pv < 0) pv = 0;
    r.temperature = 16'(tv);
    r.pressure = 18'(pv);
    r.status = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    reading_t exp_r;
    if (valid_o) begin
      if (compensated_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result t=%0d p=%0d s=%0d",
                                            temperature_o, pressure_o, status_o);
      end else begin
        exp_r = compensated_q.pop_front();
        if (temperature_o !== exp_r.temperature || pressure_o !== exp_r.pressure ||
            status_o !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected t=%0d p=%0d s=%0d, got t=%0d p=%0d s=%0d",
                     exp_r.temperature, exp_r.pressure, exp_r.status,
                     temperature_o, pressure_o, status_o);
        end
      end
    end
  end

  task automatic drain();
    while (compensated_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(bpc_pkg::cfg_reg_e idx, logic [47:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bpc_pkg::RegAc123: ac123_q = value;
      bpc_pkg::RegAc456: ac456_q = value;
      bpc_pkg::RegB1B2:  b1b2_q = value[31:0];
      bpc_pkg::RegMcMd:  mcmd_q = value[31:0];
      bpc_pkg::RegOss:   oss_q = value[1:0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(logic [47:0] ac123, logic [47:0] ac456, logic [31:0] b1b2,
                                  logic [31:0] mcmd, logic [1:0] oss);
    drain();
    write_reg(bpc_pkg::RegAc123, ac123);
    write_reg(bpc_pkg::RegAc456, ac456);
    write_reg(bpc_pkg::RegB1B2, {16'hFFFF, b1b2});
    write_reg(bpc_pkg::RegMcMd, {16'hA5A5, mcmd});
    write_reg(bpc_pkg::RegOss, {46'h1555_5555_5555, oss});
  endtask

  task automatic send_request(logic [15:0] ut, logic [18:0] up, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_i <= up;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    compensated_q.push_back(compensate(ut, up));
  endtask

  task automatic stop_requests();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  task automatic test_datasheet();
    load_calibration({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                     {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
    send_request(16'd27898, 19'd23843, 0);
    send_request(16'd0, 19'd0, 0);
    send_request(16'hFFFF, 19'h7FFFF, 0);
    send_request(16'h8000, 19'h40000, 3);
    stop_requests();
    for (int o = 1; o < 4; o++) begin
      load_calibration({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'(o));
      send_request(16'd27898, 19'(23843 << o), 0);
      send_request(16'hFFFF, 19'h7FFFF, 0);
      stop_requests();
    end
  endtask

  task automatic test_zero_divisors();
    load_calibration(48'd0, 48'd0, 32'd0, 32'd0, 2'd0);
    send_request(16'd1234, 19'd5678, 0);
    stop_requests();
    load_calibration({16'd408, -16'sd72, -16'sd14383}, {16'd0, 16'd32757, 16'd23153},
                     {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd3);
    send_request(16'd27898, 19'd1000, 0);
    stop_requests();
    load_calibration(rand48(), {16'hFFFF, 16'hFFFF, 16'hFFFF},
                     {16'h8000, 16'h7FFF}, {16'h8000, 16'h8000}, 2'd3);
    send_request(16'hFFFF, 19'h7FFFF, 0);
    send_request(16'd0, 19'd0, 0);
    stop_requests();
    load_calibration({16'h7FFF, 16'h8000, 16'h7FFF}, {16'hFFFF, 16'd0, 16'd0},
                     {16'h7FFF, 16'h8000}, {16'h7FFF, 16'h0001}, 2'd2);
    send_request(16'hFFFF, 19'h7FFFF, 0);
    send_request(16'd0, 19'd0, 0);
    stop_requests();
  endtask

  task automatic test_random_calibration(int unsigned sets, int unsigned per_set);
    for (int s = 0; s < sets; s++) begin
      if ($urandom_range(0, 3) == 0)
        load_calibration(rand48(), rand48(), $urandom, $urandom, 2'($urandom));
      else
        load_calibration({16'($urandom_range(0, 1000)), 16'($urandom_range(0, 400) - 200),
                          16'($urandom_range(0, 30000) - 15000)},
                         {16'($urandom_range(20000, 40000)), 16'($urandom_range(20000, 40000)),
                          16'($urandom_range(10000, 30000))},
                         {16'($urandom_range(4000, 8000)), 16'($urandom_range(0, 100))},
                         {16'($urandom_range(0, 16000) - 12000),
                          16'($urandom_range(1000, 4000))}, 2'($urandom));
      for (int i = 0; i < per_set; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_request(16'($urandom), 19'($urandom), $urandom_range(0, 17));
        else
          send_request(16'($urandom_range(20000, 35000)),
                       19'($urandom_range(15000, 25000) << oss_q),
                       ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
      end
      stop_requests();
    end
  endtask

  task automatic test_back_to_back();
    load_calibration(rand48(), rand48(), $urandom, $urandom, 2'($urandom));
    for (int i = 0; i < 150; i++) send_request(16'($urandom), 19'($urandom), 0);
    stop_requests();
  endtask

  initial begin
    ac123_q = '0; ac456_q = '0; b1b2_q = '0; mcmd_q = '0; oss_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_datasheet();
    test_zero_divisors();
    test_random_calibration(30, 40);
    test_back_to_back();
    drain();
    if (mismatch_count == 0)
      $display("barometric_pressure_compensation_test passed");
    else
      $display("barometric_pressure_compensation_test failed");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/bpc_pkg.sv
rtl/core/bpc_udiv.sv
rtl/core/barometric_pressure_compensation.sv
bench/barometric_pressure_compensation_test.sv
